@@ design/fpa_pkg.sv @@
// package for the q24.8 fixed-point alu: operation codes, flag bundle, defaults
// no dependencies
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int DATA_WIDTH_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 8;
	// quotient bits resolved by one divider stage
	localparam int DIV_STEP          = 4;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_INC      = 4'd4,
		OP_DEC      = 4'd5,
		OP_MIN      = 4'd6,
		OP_MAX      = 4'd7,
		OP_FROM_INT = 4'd8,
		OP_TO_INT   = 4'd9
	} op_t;

	typedef struct packed {
		logic gt;
		logic lt;
		logic eq;
		logic neg;
		logic dz;
	} flags_t;

endpackage

@@ design/fpa_div_stage.sv @@
// one registered stage of the restoring divider, DIV_STEP quotient bits per stage
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_div_stage #(
	parameter int W   = fpa_pkg::DATA_WIDTH_DEF,
	parameter int PAD = 40
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   rem_i,
	input  logic [PAD-1:0] dq_i,
	input  logic [W-1:0]   mb_i,
	output logic [W-1:0]   rem_o,
	output logic [PAD-1:0] dq_o,
	output logic [W-1:0]   mb_o
);
	import fpa_pkg::*;

	logic [W-1:0]   rem_n;
	logic [PAD-1:0] dq_n;

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	always_comb begin
		logic [W:0]     r;
		logic [W-1:0]   rem;
		logic [PAD-1:0] dq;
		rem = rem_i;
		dq  = dq_i;
		for (int k = 0; k < DIV_STEP; k++) begin
			r  = {rem, dq[PAD-1]};
			dq = {dq[PAD-2:0], 1'b0};
			if (r >= {1'b0, mb_i}) begin
				r     = r - {1'b0, mb_i};
				dq[0] = 1'b1;
			end
			rem = r[W-1:0];
		end
		rem_n = rem;
		dq_n  = dq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= rem_n;
			dq_o  <= dq_n;
			mb_o  <= mb_i;
		end
	end

endmodule

@@ design/fpa_divider.sv @@
// pipelined unsigned divider of magnitudes, dividend scaled by the fraction bits
// depends on fpa_pkg and fpa_div_stage
`timescale 1ns / 1ps

module fpa_divider #(
	parameter int W = fpa_pkg::DATA_WIDTH_DEF,
	parameter int F = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] ma,
	input  logic [W-1:0] mb,
	output logic [W-1:0] quo
);
	import fpa_pkg::*;

	localparam int N    = W + F;
	localparam int NSTG = (N + DIV_STEP - 1) / DIV_STEP;
	localparam int PAD  = NSTG * DIV_STEP;

	logic [W-1:0]   rem_c [0:NSTG];
	logic [PAD-1:0] dq_c  [0:NSTG];
	logic [W-1:0]   mb_c  [0:NSTG];

	assign rem_c[0] = '0;
	assign dq_c[0]  = PAD'(ma) << F;
	assign mb_c[0]  = mb;

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		fpa_div_stage #(.W(W), .PAD(PAD)) u_stage (
			.clk  (clk),
			.en   (en),
			.rem_i(rem_c[g]),
			.dq_i (dq_c[g]),
			.mb_i (mb_c[g]),
			.rem_o(rem_c[g+1]),
			.dq_o (dq_c[g+1]),
			.mb_o (mb_c[g+1])
		);
	end

	// only the low word survives the wrap
	assign quo = dq_c[NSTG][W-1:0];

endmodule

@@ design/fpa_mul.sv @@
// fixed-point multiplier: product register, scaling register, then alignment delay
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_mul #(
	parameter int W   = fpa_pkg::DATA_WIDTH_DEF,
	parameter int F   = fpa_pkg::FRACTION_BITS_DEF,
	parameter int LAT = 10
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic [W-1:0]        res
);
	import fpa_pkg::*;

	logic signed [2*W-1:0] prod_s2;
	logic [W-1:0]          res_q [0:LAT-2];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2  <= a * b;
			// arithmetic shift of the full product, floor rounding
			res_q[0] <= prod_s2[F+W-1:F];
			for (int i = 1; i < LAT - 1; i++) begin
				res_q[i] <= res_q[i-1];
			end
		end
	end

	assign res = res_q[LAT-2];

endmodule

@@ design/fixed_point_q24_8_alu.sv @@
// top level of the signed fixed-point alu
// depends on fpa_pkg, fpa_mul, fpa_divider
`timescale 1ns / 1ps

// Signed fixed-point ALU, DATA_WIDTH bits with FRACTION_BITS fraction bits.
// Input channel: in_valid / in_ready carry one word of operation, operand_a
// and operand_b. Output channel: out_valid / out_ready carry result and the
// greater, less, equal and divide_by_zero flags. One result per input word,
// in order.
// The path at the default Q24.8 is an input register, ten divider stages that
// resolve four quotient bits each, and the output register. Every operation
// takes the same path length. Throughput is one word per cycle while the
// receiver does not stall the pipe.
// Multiply uses one signed product register and a scaling register inside
// the same window.
// Reset clears all valid bits; the pipe comes up empty and ready.
// When the receiver holds out_ready low with a result waiting, the whole
// pipe freezes and in_ready drops; bubbles are not squeezed out, so the
// input stays held even while some stages are empty.
module fixed_point_q24_8_alu #(
	parameter int DATA_WIDTH    = fpa_pkg::DATA_WIDTH_DEF,
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [3:0]                   operation,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] result,
	output logic                         greater,
	output logic                         less,
	output logic                         equal,
	output logic                         divide_by_zero
);
	import fpa_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int F    = FRACTION_BITS;
	localparam int NSTG = (W + F + DIV_STEP - 1) / DIV_STEP;
	localparam logic [W-1:0] ONE = W'(1);

	logic adv;

	// input stage
	logic                v_s1;
	op_t                 op_s1;
	logic signed [W-1:0] a_s1;
	logic signed [W-1:0] b_s1;
	logic [W-1:0]        ma_s1;
	logic [W-1:0]        mb_s1;
	logic [W-1:0]        res_s1;
	flags_t              flg_s1;

	logic [W-1:0] res_n;
	flags_t       flg_n;
	op_t          op_n;

	// side line aligned with the divider stages
	logic         v_q   [0:NSTG-1];
	op_t          op_q  [0:NSTG-1];
	logic [W-1:0] res_q [0:NSTG-1];
	flags_t       flg_q [0:NSTG-1];

	logic [W-1:0] quo;
	logic [W-1:0] mul_res;

	// output register
	logic         out_v_q;
	logic [W-1:0] out_res_q;
	flags_t       out_flg_q;
	logic [W-1:0] fin_res;

	assign adv      = !out_v_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		op_n       = op_t'(operation);
		flg_n.gt   = operand_a > operand_b;
		flg_n.lt   = operand_a < operand_b;
		flg_n.eq   = operand_a == operand_b;
		flg_n.neg  = operand_a[W-1] ^ operand_b[W-1];
		flg_n.dz   = (op_n == OP_DIV) && (operand_b == '0);
		case (op_n)
			OP_ADD:      res_n = operand_a + operand_b;
			OP_SUB:      res_n = operand_a - operand_b;
			OP_INC:      res_n = operand_a + ONE;
			OP_DEC:      res_n = operand_a - ONE;
			OP_MIN:      res_n = flg_n.lt ? operand_a : operand_b;
			OP_MAX:      res_n = flg_n.gt ? operand_a : operand_b;
			OP_FROM_INT: res_n = operand_a << F;
			OP_TO_INT:   res_n = operand_a >>> F;
			default:     res_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < NSTG; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= in_valid;
			v_q[0]  <= v_s1;
			for (int i = 1; i < NSTG; i++) begin
				v_q[i] <= v_q[i-1];
			end
			out_v_q <= v_q[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_n;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
			ma_s1  <= operand_a[W-1] ? W'(-operand_a) : operand_a;
			mb_s1  <= operand_b[W-1] ? W'(-operand_b) : operand_b;
			res_s1 <= res_n;
			flg_s1 <= flg_n;

			op_q[0]  <= op_s1;
			res_q[0] <= res_s1;
			flg_q[0] <= flg_s1;
			for (int i = 1; i < NSTG; i++) begin
				op_q[i]  <= op_q[i-1];
				res_q[i] <= res_q[i-1];
				flg_q[i] <= flg_q[i-1];
			end

			out_res_q <= fin_res;
			out_flg_q <= flg_q[NSTG-1];
		end
	end

	fpa_divider #(.W(W), .F(F)) u_div (
		.clk(clk),
		.en (adv),
		.ma (ma_s1),
		.mb (mb_s1),
		.quo(quo)
	);

	fpa_mul #(.W(W), .F(F), .LAT(NSTG)) u_mul (
		.clk(clk),
		.en (adv),
		.a  (a_s1),
		.b  (b_s1),
		.res(mul_res)
	);

	always_comb begin
		case (op_q[NSTG-1])
			OP_MUL:  fin_res = mul_res;
			OP_DIV: begin
				if (flg_q[NSTG-1].dz) begin
					fin_res = '0;
				end else if (flg_q[NSTG-1].neg) begin
					fin_res = W'(-quo);
				end else begin
					fin_res = quo;
				end
			end
			default: fin_res = res_q[NSTG-1];
		endcase
	end

	assign out_valid      = out_v_q;
	assign result         = out_res_q;
	assign greater        = out_flg_q.gt;
	assign less           = out_flg_q.lt;
	assign equal          = out_flg_q.eq;
	assign divide_by_zero = out_flg_q.dz;

endmodule

@@ dv/fpa_checker.sv @@
// checker for the fixed-point alu: watches both channels, predicts each result word
// depends on fpa_pkg for the operation codes
`timescale 1ns / 1ps

module fpa_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [3:0]         operation,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] result,
	input  logic               greater,
	input  logic               less,
	input  logic               equal,
	input  logic               divide_by_zero,
	output int                 fail_count,
	output int                 pending
);
	import fpa_pkg::*;

	typedef struct packed {
		logic [31:0] res;
		logic        gt;
		logic        lt;
		logic        eq;
		logic        dz;
	} alu_word_t;

	alu_word_t expected_words[$];

	function automatic alu_word_t alu_predict(logic [3:0] op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_word_t w;
		logic signed [63:0] prod;
		logic signed [63:0] num;
		logic signed [63:0] quo;
		w = '0;
		w.gt = a > b;
		w.lt = a < b;
		w.eq = a == b;
		case (op)
			OP_ADD: w.res = a + b;
			OP_SUB: w.res = a - b;
			OP_MUL: begin
				prod = 64'(a) * 64'(b);
				w.res = 32'(prod >>> 8);
			end
			OP_DIV: begin
				if (b == 0) begin
					w.dz = 1'b1;
				end else begin
					// 64-bit signed divide truncates toward zero
					num = 64'(a) <<< 8;
					quo = num / 64'(b);
					w.res = quo[31:0];
				end
			end
			OP_INC: w.res = a + 32'sd1;
			OP_DEC: w.res = a - 32'sd1;
			OP_MIN: w.res = (a < b) ? a : b;
			OP_MAX: w.res = (a > b) ? a : b;
			OP_FROM_INT: w.res = a <<< 8;
			OP_TO_INT: w.res = a >>> 8;
			default: w.res = '0;
		endcase
		return w;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		alu_word_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(alu_predict(operation, operand_a, operand_b));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					errs++;
				end else begin
					e = expected_words.pop_front();
					if (result !== e.res) begin
						$error("result expected %0d actual %0d", $signed(e.res), result);
						errs++;
					end
					if (greater !== e.gt) begin
						$error("greater expected %0b actual %0b", e.gt, greater);
						errs++;
					end
					if (less !== e.lt) begin
						$error("less expected %0b actual %0b", e.lt, less);
						errs++;
					end
					if (equal !== e.eq) begin
						$error("equal expected %0b actual %0b", e.eq, equal);
						errs++;
					end
					if (divide_by_zero !== e.dz) begin
						$error("divide_by_zero expected %0b actual %0b", e.dz, divide_by_zero);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

@@ dv/tb_fixed_point_q24_8_alu.sv @@
// stimulus and verdict for the fixed-point alu
// depends on fpa_pkg, fixed_point_q24_8_alu and fpa_checker
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu;
	import fpa_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLDOFF_CYCLES = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [3:0]         operation = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] result;
	logic               greater, less, equal, divide_by_zero;
	int                 fail_count, pending;
	int                 idle_cycles = 0;
	bit                 holdoff_req = 1'b0;
	bit                 holdoff_done = 1'b0;
	int                 holdoff_cnt = 0;

	always #2 clk = ~clk;

	fixed_point_q24_8_alu u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready), .result(result),
		.greater(greater), .less(less), .equal(equal), .divide_by_zero(divide_by_zero)
	);

	fpa_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready), .result(result),
		.greater(greater), .less(less), .equal(equal), .divide_by_zero(divide_by_zero),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 2);
			1: return 32'h7fff_ffff - $urandom_range(0, 2);
			2: return 32'($signed($urandom_range(0, 1024)) - 512);
			3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// receiver: random stalls, plus one long hold-off counted here while the sender streams
	always @(posedge clk) begin
		if (holdoff_req && !holdoff_done) begin
			out_ready   <= 1'b0;
			holdoff_cnt <= holdoff_cnt + 1;
			if (holdoff_cnt == HOLDOFF_CYCLES - 1)
				holdoff_done <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 49) != 0);
		end
	end

	// watchdog over cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_fixed_point_q24_8_alu failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] edges[6];
		edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h100};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation at the extremes, divide by zero, overflowing quotient
		for (int op = 0; op < 10; op++)
			send_word(op[3:0], edges[op % 6], edges[(op + 3) % 6]);
		send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_word(OP_DIV, 32'h0000_0500, 32'h0);
		send_word(OP_DIV, 32'hffff_fb00, 32'h0000_0300);
		send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_word(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
		send_word(OP_TO_INT, 32'hffff_ff01, 32'h0);
		send_word(OP_FROM_INT, 32'h7fff_ffff, 32'h7fff_ffff);
		send_word(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
		send_word(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
		send_word(4'd10, 32'h1234_5678, 32'h1);
		send_word(4'd15, 32'hffff_ffff, 32'hffff_ffff);
		send_word(OP_INC, 32'h7fff_ffff, 32'h0);
		send_word(OP_DEC, 32'h8000_0000, 32'h0);

		for (int i = 0; i < 1350; i++) begin
			logic [3:0] op;
			logic [31:0] a;
			logic [31:0] b;
			op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			a = rand_operand();
			b = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_operand();
			if (i == 400)
				holdoff_req = 1'b1;
			send_word(op, a, ($urandom_range(0, 15) == 0) ? a : b);
			if (i == 800) begin
				// sender pauses until the pipe has drained
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end else if (i < 400 || i > 460) begin
				send_gap();
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_fixed_point_q24_8_alu passed");
		end else begin
			$display("tb_fixed_point_q24_8_alu failed");
		end
		$finish;
	end
endmodule

@@ fixed_point_q24_8_alu.f @@
design/fpa_pkg.sv
design/fpa_div_stage.sv
design/fpa_divider.sv
design/fpa_mul.sv
design/fixed_point_q24_8_alu.sv
dv/fpa_checker.sv
dv/tb_fixed_point_q24_8_alu.sv
